>>> rtl/pmra_pkg.sv
// Shared widths, limits and the derived-configuration struct for the
// patch merge reorder address generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmra_pkg;

  // word fields
  localparam int IDX_W = 24;
  localparam int PIX_W = 10;
  localparam int CH_W  = 2;
  localparam int FR_W  = 2;
  localparam int SRC_W = 26;
  localparam int DST_W = 28;

  // configuration registers
  localparam int W_W = 13;
  localparam int P_W = 6;
  localparam int M_W = 3;
  localparam int T_W = 3;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_PATCH = 32;
  localparam int CHANNELS  = 3;

  // derived values, sized for a usable configuration
  localparam int AREA_W = 11;
  localparam int TA_W   = 13;
  localparam int DV_W   = 15;
  localparam int NP_W   = 25;
  localparam int PL_W   = 25;

  // reciprocal dividers
  localparam int DIV_X_W   = 24;
  localparam int DIV_D_W   = 13;
  localparam int RCP_SHIFT = 24;
  localparam int RCP_W     = RCP_SHIFT + 1;

  // APB port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // register indexes (byte address / 4)
  localparam logic [CFG_AW-3:0] REG_WIDTH  = 'd0;
  localparam logic [CFG_AW-3:0] REG_HEIGHT = 'd1;
  localparam logic [CFG_AW-3:0] REG_PATCH  = 'd2;
  localparam logic [CFG_AW-3:0] REG_MERGE  = 'd3;
  localparam logic [CFG_AW-3:0] REG_FRAMES = 'd4;

  localparam int STAGES = 13;

  typedef struct packed {
    logic [W_W-1:0]     w;
    logic [W_W-1:0]     h;
    logic [P_W-1:0]     p;
    logic [M_W-1:0]     m;
    logic [T_W-1:0]     t;
    logic [DIV_D_W-1:0] bw;
    logic               bad;
    logic [NP_W-1:0]    npatch;
    logic [AREA_W-1:0]  area;
    logic [TA_W-1:0]    ta;
    logic [DV_W-1:0]    dvec;
    logic [PL_W-1:0]    plane;
    logic [RCP_W-1:0]   rcp_m;
    logic [RCP_W-1:0]   rcp_bw;
    logic [RCP_W-1:0]   rcp_p;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/pmra_ifs.sv
// Valid/ready channel interfaces for request and result words.
// Depends on pmra_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pmra_in_if;
  import pmra_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] patch_index;
  logic [PIX_W-1:0] pixel_in_patch;
  logic [CH_W-1:0]  channel;
  logic [FR_W-1:0]  frame;

  modport source (output valid, output patch_index, output pixel_in_patch,
                  output channel, output frame, input ready);
  modport sink (input valid, input patch_index, input pixel_in_patch,
                input channel, input frame, output ready);
endinterface

interface pmra_out_if;
  import pmra_pkg::*;
  logic             valid;
  logic             ready;
  logic [SRC_W-1:0] source_address;
  logic [DST_W-1:0] dest_address;
  logic             out_of_range;

  modport source (output valid, output source_address, output dest_address,
                  output out_of_range, input ready);
  modport sink (input valid, input source_address, input dest_address,
                input out_of_range, output ready);
endinterface

`default_nettype wire

>>> rtl/patch_merge_reorder_address.sv
// Top level: thirteen-stage address pipeline with APB configuration.
// Depends on pmra_pkg, pmra_ifs, pmra_cfg, pmra_rdiv.
//
// Channel    Dir  Handshake           Word contents
// in_word    in   valid / ready       patch_index, pixel_in_patch, channel, frame
// out_word   out  valid / ready       source_address, dest_address, out_of_range
// cfg_p*     in   APB, pready tied 1  five registers at byte address 4*i
//
// One word per cycle while out_word.ready is high and no setup pass runs. Most of the depth comes from
// three reciprocal dividers in series (merge size, merge size, blocks per row), 3 stages each.
// After reset and after every register write, a setup pass (six serial
// divisions of 25 steps each, then three multiply steps) rebuilds the derived values;
// in_word.ready stays low during it. Reset is synchronous, active low, and clears valid bits.
// A stage advances when it is empty or the next stage moves: stalls close bubbles, hold words.
`timescale 1ns / 1ps
`default_nettype none

module patch_merge_reorder_address (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  pmra_in_if.sink                         in_word,
  pmra_out_if.source                      out_word,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [pmra_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [pmra_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [pmra_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import pmra_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] pix;
    logic [CH_W-1:0]  ch;
    logic [FR_W-1:0]  fr;
    logic             oor;
    logic [M_W-1:0]   r1;
    logic [M_W-1:0]   r2;
    logic [PIX_W-1:0] prow;
    logic [P_W-1:0]   pcol;
  } item_t;

  cfg_t dcfg;
  logic cfg_rdy;

  logic [STAGES:1] v_r, v_in, en;
  item_t           item_in;
  item_t           carry_r   [1:STAGES];
  item_t           carry_nxt [1:STAGES];

  logic [DIV_X_W-1:0] div_a_q, div_b_q, div_c_q, div_p_q;
  logic [DIV_D_W-1:0] div_a_r, div_b_r, div_c_r, div_p_r;

  logic [26:0]      rp_r;
  logic [15:0]      cp_r;
  logic [32:0]      row_r;
  logic [21:0]      col_r;
  logic [SRC_W-1:0] roww_r, chpl_r;
  logic [W_W-1:0]   col12_r;
  logic [DST_W-1:0] idxd_r;
  logic [DV_W-1:0]  chta_r;
  logic [12:0]      fra_r;
  logic [SRC_W-1:0] src_r;
  logic [DST_W-1:0] dst_r;

  pmra_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (dcfg),
    .cfg_rdy (cfg_rdy)
  );

  // stage enables: a stage loads when it is empty or everything after it can drain
  always_comb begin
    for (int k = 1; k <= STAGES; k++) begin
      en[k] = out_word.ready || !(&(v_r | STAGES'((1 << (k - 1)) - 1)));
    end
  end

  assign in_word.ready = en[1] && cfg_rdy;
  assign v_in          = {v_r[STAGES-1:1], in_word.valid && cfg_rdy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (en & v_in) | (~en & v_r);
    end
  end

  always_comb begin
    item_in.idx  = in_word.patch_index;
    item_in.pix  = in_word.pixel_in_patch;
    item_in.ch   = in_word.channel;
    item_in.fr   = in_word.frame;
    item_in.oor  = dcfg.bad ||
                   (NP_W'(in_word.patch_index) >= dcfg.npatch) ||
                   (AREA_W'(in_word.pixel_in_patch) >= dcfg.area) ||
                   (in_word.channel >= CH_W'(CHANNELS)) ||
                   (T_W'(in_word.frame) >= dcfg.t);
    item_in.r1   = '0;
    item_in.r2   = '0;
    item_in.prow = '0;
    item_in.pcol = '0;
  end

  // stages 1-3: patch index / merge, pixel / patch side
  pmra_rdiv u_div_a (
    .clk   (clk),
    .en    (en[3:1]),
    .x     (in_word.patch_index),
    .d     (DIV_D_W'(dcfg.m)),
    .recip (dcfg.rcp_m),
    .q     (div_a_q),
    .r     (div_a_r)
  );

  pmra_rdiv u_div_p (
    .clk   (clk),
    .en    (en[3:1]),
    .x     (DIV_X_W'(in_word.pixel_in_patch)),
    .d     (DIV_D_W'(dcfg.p)),
    .recip (dcfg.rcp_p),
    .q     (div_p_q),
    .r     (div_p_r)
  );

  // stages 4-6: second merge split
  pmra_rdiv u_div_b (
    .clk   (clk),
    .en    (en[6:4]),
    .x     (div_a_q),
    .d     (DIV_D_W'(dcfg.m)),
    .recip (dcfg.rcp_m),
    .q     (div_b_q),
    .r     (div_b_r)
  );

  // stages 7-9: block row and block column
  pmra_rdiv u_div_c (
    .clk   (clk),
    .en    (en[9:7]),
    .x     (div_b_q),
    .d     (dcfg.bw),
    .recip (dcfg.rcp_bw),
    .q     (div_c_q),
    .r     (div_c_r)
  );

  always_comb begin
    carry_nxt[1] = item_in;
    for (int k = 2; k <= STAGES; k++) begin
      carry_nxt[k] = carry_r[k-1];
    end
    carry_nxt[4].r1   = div_a_r[M_W-1:0];
    carry_nxt[4].prow = div_p_q[PIX_W-1:0];
    carry_nxt[4].pcol = div_p_r[P_W-1:0];
    carry_nxt[7].r2   = div_b_r[M_W-1:0];
    carry_nxt[12].oor = carry_r[11].oor || (row_r >= 33'(dcfg.h)) ||
                        (col_r >= 22'(dcfg.w));
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= STAGES; k++) begin
      if (en[k]) begin
        carry_r[k] <= carry_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    // stage 10: patch row / column in patch units
    if (en[10]) begin
      rp_r <= 27'(div_c_q) * 27'(dcfg.m) + 27'(carry_r[9].r2);
      cp_r <= 16'(div_c_r) * 16'(dcfg.m) + 16'(carry_r[9].r1);
    end
    // stage 11: pixel row / column
    if (en[11]) begin
      row_r <= 33'(rp_r) * 33'(dcfg.p) + 33'(carry_r[10].prow);
      col_r <= 22'(cp_r) * 22'(dcfg.p) + 22'(carry_r[10].pcol);
    end
    // stage 12: address terms
    if (en[12]) begin
      roww_r  <= SRC_W'(row_r[W_W-1:0]) * SRC_W'(dcfg.w);
      col12_r <= col_r[W_W-1:0];
      chpl_r  <= SRC_W'(carry_r[11].ch) * SRC_W'(dcfg.plane);
      idxd_r  <= DST_W'(carry_r[11].idx) * DST_W'(dcfg.dvec);
      chta_r  <= DV_W'(carry_r[11].ch) * DV_W'(dcfg.ta);
      fra_r   <= 13'(carry_r[11].fr) * 13'(dcfg.area);
    end
    // stage 13: output word
    if (en[13]) begin
      src_r <= carry_r[12].oor ? '0 : chpl_r + roww_r + SRC_W'(col12_r);
      dst_r <= carry_r[12].oor ? '0 :
               idxd_r + DST_W'(chta_r) + DST_W'(fra_r) + DST_W'(carry_r[12].pix);
    end
  end

  assign out_word.valid          = v_r[STAGES];
  assign out_word.source_address = src_r;
  assign out_word.dest_address   = dst_r;
  assign out_word.out_of_range   = carry_r[STAGES].oor;

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.valid && in_word.ready |=> v_r[1])
    else $error("accepted word did not enter stage 1");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STAGES-1] && en[STAGES] |=> v_r[STAGES])
    else $error("word lost between last two stages");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STAGES-1] && !en[STAGES-1] |=> v_r[STAGES-1])
    else $error("stalled stage dropped its word");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && out_word.out_of_range |->
      out_word.source_address == '0 && out_word.dest_address == '0)
    else $error("flagged word carries nonzero addresses");

endmodule

`default_nettype wire

>>> rtl/pmra_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Used by the setup sequencer; depends on pmra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmra_sdiv (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [pmra_pkg::RCP_W-1:0]   dividend,
  input  wire logic [pmra_pkg::DIV_D_W-1:0] divisor,
  output logic                             done,
  output logic [pmra_pkg::RCP_W-1:0]        quotient
);
  import pmra_pkg::*;

  localparam int CNT_W = $clog2(RCP_W + 1);

  logic [RCP_W-1:0]   quo_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W-1:0] rem_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               run_r;
  logic               done_r;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               ge;

  always_comb begin
    trial   = {rem_r, quo_r[RCP_W-1]};
    ge      = trial >= {1'b0, divisor};
    diff    = trial - {1'b0, divisor};
    rem_nxt = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(RCP_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= {quo_r[RCP_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> rtl/pmra_cfg.sv
// APB register file and setup sequencer that derives grid sizes, products
// and reciprocals after reset and each write. Depends on pmra_pkg, pmra_sdiv.
`timescale 1ns / 1ps
`default_nettype none

module pmra_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pmra_pkg::CFG_AW-1:0] paddr,
  input  wire logic [pmra_pkg::CFG_DW-1:0] pwdata,
  output logic [pmra_pkg::CFG_DW-1:0]      prdata,
  output logic                            pready,
  output pmra_pkg::cfg_t                  cfg,
  output logic                            cfg_rdy
);
  import pmra_pkg::*;

  localparam logic [2:0] OP_GW  = 3'd0;
  localparam logic [2:0] OP_GH  = 3'd1;
  localparam logic [2:0] OP_BW  = 3'd2;
  localparam logic [2:0] OP_RM  = 3'd3;
  localparam logic [2:0] OP_RBW = 3'd4;
  localparam logic [2:0] OP_RP  = 3'd5;

  localparam logic [RCP_W-1:0] RCP_ONE = {1'b1, {RCP_SHIFT{1'b0}}};

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DSTART = 6'b000010,
    ST_DWAIT  = 6'b000100,
    ST_MUL1   = 6'b001000,
    ST_MUL2   = 6'b010000,
    ST_MUL3   = 6'b100000
  } seq_state_t;

  seq_state_t state_r, state_nxt;
  logic [2:0] op_r, op_nxt;

  logic [W_W-1:0] w_r, h_r;
  logic [P_W-1:0] p_r;
  logic [M_W-1:0] m_r;
  logic [T_W-1:0] t_r;

  logic [W_W-1:0]     gw_r, gh_r;
  logic [DIV_D_W-1:0] bw_r;
  logic [RCP_W-1:0]   rcp_m_r, rcp_bw_r, rcp_p_r;
  logic [NP_W-1:0]    npatch_r;
  logic [AREA_W-1:0]  area_r;
  logic [PL_W-1:0]    plane_r;
  logic [TA_W-1:0]    ta_r;
  logic [DV_W-1:0]    dvec_r;
  logic               bad_r;

  logic [CFG_AW-3:0]  ridx;
  logic               wr_en;
  logic               start;
  logic               done;
  logic [RCP_W-1:0]   dvd;
  logic [DIV_D_W-1:0] dvs;
  logic [RCP_W-1:0]   quo;
  logic               bad_nxt;

  assign ridx   = paddr[CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= W_W'(448);
      h_r <= W_W'(448);
      p_r <= P_W'(14);
      m_r <= M_W'(2);
      t_r <= T_W'(2);
    end else if (wr_en) begin
      case (ridx)
        REG_WIDTH:  w_r <= pwdata[W_W-1:0];
        REG_HEIGHT: h_r <= pwdata[W_W-1:0];
        REG_PATCH:  p_r <= pwdata[P_W-1:0];
        REG_MERGE:  m_r <= pwdata[M_W-1:0];
        REG_FRAMES: t_r <= pwdata[T_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_WIDTH:  prdata = CFG_DW'(w_r);
      REG_HEIGHT: prdata = CFG_DW'(h_r);
      REG_PATCH:  prdata = CFG_DW'(p_r);
      REG_MERGE:  prdata = CFG_DW'(m_r);
      REG_FRAMES: prdata = CFG_DW'(t_r);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    case (op_r)
      OP_GW:   begin dvd = RCP_W'(w_r);  dvs = DIV_D_W'(p_r); end
      OP_GH:   begin dvd = RCP_W'(h_r);  dvs = DIV_D_W'(p_r); end
      OP_BW:   begin dvd = RCP_W'(gw_r); dvs = DIV_D_W'(m_r); end
      OP_RM:   begin dvd = RCP_ONE;      dvs = DIV_D_W'(m_r); end
      OP_RBW:  begin dvd = RCP_ONE;      dvs = bw_r;          end
      OP_RP:   begin dvd = RCP_ONE;      dvs = DIV_D_W'(p_r); end
      default: begin dvd = '0;           dvs = DIV_D_W'(1);   end
    endcase
  end

  pmra_sdiv u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (done),
    .quotient (quo)
  );

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    start     = 1'b0;
    case (state_r)
      ST_IDLE: ;
      ST_DSTART: begin
        start     = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (done) begin
          if (op_r == OP_RP) begin
            state_nxt = ST_MUL1;
          end else begin
            op_nxt    = op_r + 3'd1;
            state_nxt = ST_DSTART;
          end
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_IDLE;
      default: state_nxt = ST_DSTART;
    endcase
    if (wr_en) begin
      state_nxt = ST_DSTART;
      op_nxt    = OP_GW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DSTART;
      op_r    <= OP_GW;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign bad_nxt = (w_r == '0) || (h_r == '0) || (p_r == '0) || (m_r == '0) || (t_r == '0) ||
                   (w_r > W_W'(MAX_WIDTH)) || (h_r > W_W'(MAX_WIDTH)) ||
                   (p_r > P_W'(MAX_PATCH)) || (bw_r == '0);

  always_ff @(posedge clk) begin
    if (state_r == ST_DWAIT && done) begin
      case (op_r)
        OP_GW:   gw_r     <= quo[W_W-1:0];
        OP_GH:   gh_r     <= quo[W_W-1:0];
        OP_BW:   bw_r     <= quo[DIV_D_W-1:0];
        OP_RM:   rcp_m_r  <= quo;
        OP_RBW:  rcp_bw_r <= quo;
        OP_RP:   rcp_p_r  <= quo;
        default: ;
      endcase
    end
    if (state_r == ST_MUL1) begin
      npatch_r <= NP_W'(gw_r * gh_r);
      area_r   <= AREA_W'(p_r * p_r);
      plane_r  <= PL_W'(h_r * w_r);
      bad_r    <= bad_nxt;
    end
    if (state_r == ST_MUL2) begin
      ta_r <= TA_W'(t_r * area_r);
    end
    if (state_r == ST_MUL3) begin
      dvec_r <= DV_W'(DV_W'(CHANNELS) * DV_W'(ta_r));
    end
  end

  always_comb begin
    cfg.w      = w_r;
    cfg.h      = h_r;
    cfg.p      = p_r;
    cfg.m      = m_r;
    cfg.t      = t_r;
    cfg.bw     = bw_r;
    cfg.bad    = bad_r;
    cfg.npatch = npatch_r;
    cfg.area   = area_r;
    cfg.ta     = ta_r;
    cfg.dvec   = dvec_r;
    cfg.plane  = plane_r;
    cfg.rcp_m  = rcp_m_r;
    cfg.rcp_bw = rcp_bw_r;
    cfg.rcp_p  = rcp_p_r;
  end

  assign cfg_rdy = (state_r == ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/pmra_rdiv.sv
// Three-stage divider by multiplication with a precomputed reciprocal,
// one-step correction in the last stage. Depends on pmra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmra_rdiv (
  input  wire logic                        clk,
  input  wire logic [2:0]                  en,
  input  wire logic [pmra_pkg::DIV_X_W-1:0] x,
  input  wire logic [pmra_pkg::DIV_D_W-1:0] d,
  input  wire logic [pmra_pkg::RCP_W-1:0]   recip,
  output logic [pmra_pkg::DIV_X_W-1:0]      q,
  output logic [pmra_pkg::DIV_D_W-1:0]      r
);
  import pmra_pkg::*;

  logic [DIV_X_W+RCP_W-1:0]   prod;
  logic [DIV_X_W+DIV_D_W-1:0] back_full;
  logic [DIV_X_W-1:0]         qe1_r, x1_r;
  logic [DIV_X_W-1:0]         qe2_r, x2_r, back_r;
  logic [DIV_X_W-1:0]         rem, diff;
  logic                       fix;
  logic [DIV_X_W-1:0]         q_r;
  logic [DIV_D_W-1:0]         r_r;

  // estimate is exact or one low
  assign prod      = (DIV_X_W+RCP_W)'(x) * (DIV_X_W+RCP_W)'(recip);
  assign back_full = (DIV_X_W+DIV_D_W)'(qe1_r) * (DIV_X_W+DIV_D_W)'(d);

  always_comb begin
    rem  = x2_r - back_r;
    diff = rem - DIV_X_W'(d);
    fix  = rem >= DIV_X_W'(d);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      qe1_r <= prod[RCP_SHIFT +: DIV_X_W];
      x1_r  <= x;
    end
    if (en[1]) begin
      back_r <= back_full[DIV_X_W-1:0];
      qe2_r  <= qe1_r;
      x2_r   <= x1_r;
    end
    if (en[2]) begin
      q_r <= fix ? qe2_r + DIV_X_W'(1) : qe2_r;
      r_r <= fix ? diff[DIV_D_W-1:0] : rem[DIV_D_W-1:0];
    end
  end

  assign q = q_r;
  assign r = r_r;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking bench for the patch merge reorder address generator.
// Depends on pmra_pkg, pmra_ifs and the patch_merge_reorder_address RTL.
// Phases of directed and random request words under varied configurations.
`timescale 1ns / 1ps

module tb_top;
  import pmra_pkg::*;

  // an index with no register behind it
  localparam logic [CFG_AW-3:0] REG_UNUSED = REG_FRAMES + 3'd1;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] pix;
    logic [CH_W-1:0]  ch;
    logic [FR_W-1:0]  fr;
  } req_t;

  typedef struct {
    logic [SRC_W-1:0] src;
    logic [DST_W-1:0] dst;
    logic             oor;
  } addr_t;

  bit clk = 1'b0;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  pmra_in_if  in_if ();
  pmra_out_if out_if ();

  patch_merge_reorder_address dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_if.sink),
    .out_word    (out_if.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the configuration registers
  logic [W_W-1:0] img_w;
  logic [W_W-1:0] img_h;
  logic [P_W-1:0] patch_p;
  logic [M_W-1:0] merge_m;
  logic [T_W-1:0] frames_t;

  req_t  req_q[$];
  addr_t want_q[$];
  bit    in_fire;
  bit    calm;
  int    errors;
  req_t  cur_req;

  always #5 clk = ~clk;

  function automatic addr_t predict_addr(req_t q);
    longint unsigned w, h, p, m, t, gw, gh, bw, area, row, col, idx, pix, ch, fr;
    addr_t a;
    a.src = '0;
    a.dst = '0;
    a.oor = 1'b1;
    w = img_w;
    h = img_h;
    p = patch_p;
    m = merge_m;
    t = frames_t;
    idx = q.idx;
    pix = q.pix;
    ch = q.ch;
    fr = q.fr;
    if (w == 0 || h == 0 || p == 0 || m == 0 || t == 0) return a;
    if (w > MAX_WIDTH || h > MAX_WIDTH || p > MAX_PATCH) return a;
    gw = w / p;
    gh = h / p;
    bw = gw / m;
    area = p * p;
    if (bw == 0) return a;
    if (idx >= gw * gh || pix >= area || ch >= CHANNELS || fr >= t) return a;
    row = ((idx / (m * m * bw)) * m + (idx / m) % m) * p + pix / p;
    col = (((idx / (m * m)) % bw) * m + idx % m) * p + pix % p;
    if (row >= h || col >= w) return a;
    a.src = SRC_W'(ch * h * w + row * w + col);
    a.dst = DST_W'(idx * (CHANNELS * t * area) + ch * t * area + fr * area + pix);
    a.oor = 1'b0;
    return a;
  endfunction

  function automatic bit stall_now();
    return !calm && ($urandom_range(0, 99) < 11);
  endfunction

  // shaped words stay mostly inside the configured bounds
  function automatic req_t random_req(bit shaped);
    longint unsigned np, area;
    req_t q;
    q.idx = IDX_W'($urandom);
    q.pix = PIX_W'($urandom);
    q.ch  = CH_W'($urandom);
    q.fr  = FR_W'($urandom);
    if (shaped && patch_p != 0) begin
      np = (longint'(img_w) / patch_p) * (longint'(img_h) / patch_p);
      if (np > (1 << IDX_W)) np = 1 << IDX_W;
      area = longint'(patch_p) * patch_p;
      if (np > 0) q.idx = IDX_W'(($urandom_range(0, 9) == 0) ? np - 1 : $urandom % np);
      if (area <= 1024)
        q.pix = PIX_W'(($urandom_range(0, 9) == 0) ? area - 1 : $urandom % area);
      q.ch = CH_W'($urandom_range(0, CHANNELS - 1));
      if (frames_t != 0) q.fr = FR_W'($urandom_range(0, (frames_t > 4) ? 3 : frames_t - 1));
    end
    return q;
  endfunction

  task automatic push_req(int unsigned idx, int unsigned pix, int unsigned ch,
                          int unsigned fr);
    req_t q;
    q.idx = IDX_W'(idx);
    q.pix = PIX_W'(pix);
    q.ch  = CH_W'(ch);
    q.fr  = FR_W'(fr);
    req_q.push_back(q);
  endtask

  task automatic push_random(int n);
    repeat (n) req_q.push_back(random_req($urandom_range(0, 99) < 85));
  endtask

  task automatic write_reg(logic [CFG_AW-3:0] r, int unsigned val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= CFG_DW'(val);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_cfg(int unsigned w, int unsigned h, int unsigned p,
                         int unsigned m, int unsigned t);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_PATCH, p);
    write_reg(REG_MERGE, m);
    write_reg(REG_FRAMES, t);
    img_w    = W_W'(w);
    img_h    = W_W'(h);
    patch_p  = P_W'(p);
    merge_m  = M_W'(m);
    frames_t = T_W'(t);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (req_q.size() != 0 || in_if.valid || want_q.size() != 0);
  endtask

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (req_q.size() > 0 && !stall_now()) begin
        cur_req = req_q.pop_front();
        in_if.patch_index    <= cur_req.idx;
        in_if.pixel_in_patch <= cur_req.pix;
        in_if.channel        <= cur_req.ch;
        in_if.frame          <= cur_req.fr;
        in_if.valid          <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= !stall_now();
  end

  // acceptance tracking and result checking
  always @(posedge clk) begin
    in_fire <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      cur_req.idx = in_if.patch_index;
      cur_req.pix = in_if.pixel_in_patch;
      cur_req.ch  = in_if.channel;
      cur_req.fr  = in_if.frame;
      want_q.push_back(predict_addr(cur_req));
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (want_q.size() == 0) begin
        flag_error($sformatf("unexpected word src=%0h dst=%0h oor=%0b",
                             out_if.source_address, out_if.dest_address,
                             out_if.out_of_range));
      end else begin
        addr_t e;
        e = want_q.pop_front();
        if (out_if.source_address !== e.src || out_if.dest_address !== e.dst ||
            out_if.out_of_range !== e.oor)
          flag_error($sformatf("mismatch: exp src=%0h dst=%0h oor=%0b, got src=%0h dst=%0h oor=%0b",
                               e.src, e.dst, e.oor, out_if.source_address,
                               out_if.dest_address, out_if.out_of_range));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[patch_merge_reorder_address] ERROR");
    $finish;
  end

  initial begin
    int unsigned p, m, t;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.patch_index = '0;
    in_if.pixel_in_patch = '0;
    in_if.channel = '0;
    in_if.frame = '0;
    out_if.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_fire = 1'b0;
    calm = 1'b0;
    errors = 0;
    img_w = 448;
    img_h = 448;
    patch_p = 14;
    merge_m = 2;
    frames_t = 2;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: a 32x32 grid of patches, area 196, two frames
    push_req(0, 0, 0, 0);
    push_req(1023, 195, 2, 1);
    push_req(1024, 0, 0, 0);
    push_req(24'hFFFFFF, 0, 0, 0);
    push_req(5, 196, 0, 0);
    push_req(5, 10'h3FF, 1, 0);
    push_req(7, 3, 3, 0);
    push_req(9, 100, 1, 2);
    push_req(9, 100, 1, 3);
    push_req(513, 77, 1, 1);
    push_req(30, 50, 2, 0);
    wait_drained();

    set_cfg(4096, 4096, 1, 4, 4);
    push_req(0, 0, 0, 0);
    push_req(24'hFFFFFF, 0, 2, 3);
    push_req(24'hAAAAAA, 0, 1, 2);
    push_req(24'h555555, 0, 0, 1);
    push_req(123456, 1, 0, 0);
    wait_drained();

    set_cfg(4096, 4096, 32, 1, 1);
    push_req(16383, 1023, 2, 0);
    push_req(16384, 0, 0, 0);
    push_req(200, 1023, 1, 1);
    wait_drained();

    set_cfg(1, 1, 1, 1, 1);
    push_req(0, 0, 0, 0);
    push_req(1, 0, 0, 0);
    wait_drained();

    // patches per row not a multiple of the merge size
    set_cfg(100, 60, 7, 3, 3);
    write_reg(REG_UNUSED, 32'h0000_0123);
    push_req(70, 0, 0, 0);
    push_req(107, 48, 2, 2);
    push_req(111, 0, 0, 0);
    push_random(20);
    wait_drained();

    // unusable settings, then a usable one with merge size and frame count 7
    set_cfg(448, 448, 14, 0, 2);
    push_req(3, 5, 1, 0);
    wait_drained();
    set_cfg(448, 448, 14, 2, 0);
    push_req(3, 5, 1, 0);
    wait_drained();
    set_cfg(5000, 448, 14, 2, 2);
    push_req(3, 5, 1, 0);
    wait_drained();
    set_cfg(448, 448, 40, 2, 2);
    push_req(3, 5, 1, 0);
    wait_drained();
    set_cfg(20, 448, 8, 4, 2);
    push_req(0, 0, 0, 0);
    wait_drained();
    set_cfg(0, 8191, 0, 7, 7);
    push_req(0, 0, 0, 0);
    wait_drained();
    set_cfg(300, 200, 5, 7, 7);
    push_random(10);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      p = $urandom_range(1, 32);
      m = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
      t = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
      if (p * m > 4096) m = 1;
      set_cfg($urandom_range(p * m, 4096), $urandom_range(p, 4096), p, m, t);
      calm = (ph == 3);
      push_random(50);
      wait_drained();
    end
    calm = 1'b0;

    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("[patch_merge_reorder_address] OK");
    end else begin
      $display("[patch_merge_reorder_address] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pmra_pkg.sv
rtl/pmra_ifs.sv
rtl/pmra_sdiv.sv
rtl/pmra_cfg.sv
rtl/pmra_rdiv.sv
rtl/patch_merge_reorder_address.sv
test/tb_top.sv
